### src/lpg_pkg.sv
// lpg_pkg: shared types, constants and helpers of the line pixel generator
// holds the transfer structs, microcode control word and status types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lpg_pkg;

	localparam int SCREEN_SIZE = 128;
	localparam int COORD_W     = 7;
	localparam int ERR_W       = COORD_W + 2;
	localparam int UPC_W       = 3;

	localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(SCREEN_SIZE - 1);

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [UPC_W-1:0]   upc_t;

	// request: two end points
	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} req_t;

	// result: two pixels, mark for the second, end of line
	typedef struct packed {
		coord_t first_px;
		coord_t first_py;
		coord_t second_px;
		coord_t second_py;
		logic   second_valid;
		logic   last;
	} pix_t;

	// datapath operations
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_SETUP,
		OP_FIRST,
		OP_SECOND,
		OP_ODD
	} dp_op_t;

	// condition a step waits on before it executes
	typedef enum logic [1:0] {
		WAIT_NONE,
		WAIT_REQ,
		WAIT_OUT
	} wait_t;

	// sequencing after a step
	typedef enum logic [1:0] {
		BR_NEXT,
		BR_ALWAYS,
		BR_DONE,
		BR_NOT_DONE
	} branch_t;

	// microprogram step addresses
	localparam upc_t STEP_IDLE   = UPC_W'(0);
	localparam upc_t STEP_SETUP  = UPC_W'(1);
	localparam upc_t STEP_FIRST  = UPC_W'(2);
	localparam upc_t STEP_SECOND = UPC_W'(3);
	localparam upc_t STEP_WRAP   = UPC_W'(4);
	localparam upc_t STEP_ODD    = UPC_W'(5);

	typedef struct packed {
		logic    req_ready;
		dp_op_t  op;
		wait_t   wait_on;
		branch_t branch;
		upc_t    target;
	} ctrl_t;

	// datapath status back to the sequencer
	typedef struct packed {
		logic done;
		logic out_free;
	} stat_t;

	function automatic coord_t clamp_coord(input coord_t v);
		clamp_coord = (v > COORD_MAX) ? COORD_MAX : v;
	endfunction

endpackage

`default_nettype wire

### src/lpg_seq.sv
// lpg_seq: microcode rom and step counter of the line pixel generator
// depends on lpg_pkg for the control word and status types
`timescale 1ns / 1ps
`default_nettype none

module lpg_seq
	import lpg_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  req_valid,
	output logic       req_stall,
	input  wire stat_t stat,
	output ctrl_t      ctrl
);

	upc_t  upc_q;
	upc_t  upc_d;
	ctrl_t cw;
	logic  go;
	logic  taken;

	function automatic ctrl_t ucode_rom(input upc_t s);
		ctrl_t w;
		w = '{req_ready: 1'b0, op: OP_NONE, wait_on: WAIT_NONE,
		      branch: BR_ALWAYS, target: STEP_IDLE};
		unique case (s)
			STEP_IDLE: begin
				w.req_ready = 1'b1;
				w.op        = OP_LOAD;
				w.wait_on   = WAIT_REQ;
				w.branch    = BR_NEXT;
			end
			STEP_SETUP: begin
				w.op     = OP_SETUP;
				w.branch = BR_NEXT;
			end
			STEP_FIRST: begin
				w.op     = OP_FIRST;
				w.branch = BR_DONE;
				w.target = STEP_ODD;
			end
			STEP_SECOND: begin
				w.op      = OP_SECOND;
				w.wait_on = WAIT_OUT;
				w.branch  = BR_NOT_DONE;
				w.target  = STEP_FIRST;
			end
			STEP_WRAP: begin
				w.branch = BR_ALWAYS;
			end
			STEP_ODD: begin
				w.op      = OP_ODD;
				w.wait_on = WAIT_OUT;
				w.branch  = BR_ALWAYS;
			end
			default: begin
				w.branch = BR_ALWAYS;
			end
		endcase
		ucode_rom = w;
	endfunction

	always_comb begin
		cw = ucode_rom(upc_q);

		unique case (cw.wait_on)
			WAIT_NONE: go = 1'b1;
			WAIT_REQ:  go = req_valid;
			WAIT_OUT:  go = stat.out_free;
			default:   go = 1'b0;
		endcase

		unique case (cw.branch)
			BR_NEXT:     taken = 1'b0;
			BR_ALWAYS:   taken = 1'b1;
			BR_DONE:     taken = stat.done;
			BR_NOT_DONE: taken = !stat.done;
			default:     taken = 1'b0;
		endcase

		if (!go) begin
			upc_d = upc_q;
		end else if (taken) begin
			upc_d = cw.target;
		end else begin
			upc_d = upc_q + 1'b1;
		end

		ctrl = cw;
		if (!go) begin
			ctrl.op = OP_NONE;
		end
	end

	assign req_stall = !cw.req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

`default_nettype wire

### src/lpg_datapath.sv
// lpg_datapath: coordinate, error and output registers of the line pixel generator
// driven by the lpg_seq control word; depends on lpg_pkg
`timescale 1ns / 1ps
`default_nettype none

module lpg_datapath
	import lpg_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire req_t  req,
	input  wire ctrl_t ctrl,
	input  wire logic  pix_stall,
	output stat_t      stat,
	output logic       pix_valid,
	output pix_t       pix
);

	coord_t ax_q, ay_q, bx_q, by_q;
	logic   steep_q;
	logic   step_neg_q;
	coord_t maj_q, min_q, maj_end_q;
	coord_t dmaj_q, dmin_q;
	logic signed [ERR_W-1:0] err_q;
	coord_t first_px_q, first_py_q;
	logic   out_valid_q;
	pix_t   out_q;

	// setup terms
	coord_t dx, dy;
	logic   steep, swap;
	coord_t m0, n0, m1, n1;

	// bresenham advance
	logic signed [ERR_W-1:0] err_sub;
	logic signed [ERR_W-1:0] err_next;
	coord_t min_next;
	coord_t cur_px, cur_py;
	logic   advance;

	always_comb begin
		dx    = (ax_q > bx_q) ? (ax_q - bx_q) : (bx_q - ax_q);
		dy    = (ay_q > by_q) ? (ay_q - by_q) : (by_q - ay_q);
		steep = dy > dx;
		m0    = steep ? ay_q : ax_q;
		n0    = steep ? ax_q : ay_q;
		m1    = steep ? by_q : bx_q;
		n1    = steep ? bx_q : by_q;
		swap  = m0 > m1;

		err_sub = err_q - $signed({2'b00, dmin_q});
		if (err_sub[ERR_W-1]) begin
			min_next = step_neg_q ? (min_q - 1'b1) : (min_q + 1'b1);
			err_next = err_sub + $signed({2'b00, dmaj_q});
		end else begin
			min_next = min_q;
			err_next = err_sub;
		end

		cur_px  = steep_q ? min_q : maj_q;
		cur_py  = steep_q ? maj_q : min_q;
		advance = (ctrl.op == OP_FIRST) || (ctrl.op == OP_SECOND);
	end

	assign stat.done     = (maj_q == maj_end_q);
	assign stat.out_free = !out_valid_q || !pix_stall;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				ax_q <= clamp_coord(req.start_x);
				ay_q <= clamp_coord(req.start_y);
				bx_q <= clamp_coord(req.end_x);
				by_q <= clamp_coord(req.end_y);
			end
			OP_SETUP: begin
				steep_q    <= steep;
				maj_q      <= swap ? m1 : m0;
				maj_end_q  <= swap ? m0 : m1;
				min_q      <= swap ? n1 : n0;
				step_neg_q <= swap ? (n1 >= n0) : (n0 >= n1);
				dmaj_q     <= steep ? dy : dx;
				dmin_q     <= steep ? dx : dy;
				err_q      <= $signed({2'b00, (steep ? dy : dx) >> 1});
			end
			OP_FIRST: begin
				first_px_q <= cur_px;
				first_py_q <= cur_py;
			end
			OP_SECOND: begin
				out_q <= '{first_px: first_px_q, first_py: first_py_q,
				           second_px: cur_px, second_py: cur_py,
				           second_valid: 1'b1, last: stat.done};
			end
			OP_ODD: begin
				out_q <= '{first_px: first_px_q, first_py: first_py_q,
				           second_px: '0, second_py: '0,
				           second_valid: 1'b0, last: 1'b1};
			end
			default: begin
			end
		endcase

		if (advance) begin
			maj_q <= maj_q + 1'b1;
			min_q <= min_next;
			err_q <= err_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctrl.op == OP_SECOND) || (ctrl.op == OP_ODD)) begin
			out_valid_q <= 1'b1;
		end else if (!pix_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign pix_valid = out_valid_q;
	assign pix       = out_q;

endmodule

`default_nettype wire

### src/line_pixel_generator.sv
// line_pixel_generator: bresenham line rasterizer, up to two pixels per result
// the first result is written to the output register in the second (or odd) step, after idle, setup and first
// a new request is taken only back in idle, once every pixel of the line has had a first
//   or second step and the wrap or odd step has run; output stalls hold the second and odd steps
// reset: arst_n clears the step counter and the output valid; payload is not reset
// depends on lpg_pkg, lpg_seq and lpg_datapath
`timescale 1ns / 1ps
`default_nettype none

module line_pixel_generator
	import lpg_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	// request channel
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	// pixel channel
	output logic      pix_valid,
	input  wire logic pix_stall,
	output pix_t      pix
);

	// control word from the rom, its op already gated by the wait condition
	ctrl_t ctrl;
	// done and output-free flags for waits and branches
	stat_t stat;

	// microprogram:
	//   idle   - take a request (waits for req_valid), clamp and hold end points
	//   setup  - pick major axis, order end points, extents, initial error
	//   first  - park current pixel as first of the pair, step; last pixel -> odd
	//   second - wait for free output register, write pair, step; more -> first
	//   wrap   - back to idle after an even pixel count
	//   odd    - wait for free output register, write lone pixel with last set
	lpg_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	// coordinate and error registers plus the output register; the output
	// register lets the sequencer move on while a result waits for transfer
	lpg_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctrl      (ctrl),
		.pix_stall (pix_stall),
		.stat      (stat),
		.pix_valid (pix_valid),
		.pix       (pix)
	);

endmodule

`default_nettype wire

### src/lpg_checker.sv
// lpg_checker: port-level checks of the line pixel generator
// bound to line_pixel_generator; depends on lpg_pkg
`timescale 1ns / 1ps
`default_nettype none

module lpg_checker
	import lpg_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire req_t req,
	input wire logic pix_valid,
	input wire logic pix_stall,
	input wire pix_t pix
);

	// a stalled result holds
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(pix))
		else $error("stalled result changed");

	// a request is never taken back to back: a transfer is followed by req_stall
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken back to back");

	// a lone pixel only ends a line, with an empty second slot
	a_odd_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix.second_valid |->
			pix.last && pix.second_px == 0 && pix.second_py == 0)
		else $error("bad lone pixel result");

	// the two pixels of a pair are neighbors
	a_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix.second_valid |->
			(pix.first_px == pix.second_px || pix.first_px + 1 == pix.second_px ||
			 pix.second_px + 1 == pix.first_px) &&
			(pix.first_py == pix.second_py || pix.first_py + 1 == pix.second_py ||
			 pix.second_py + 1 == pix.first_py))
		else $error("pixel pair not adjacent");

endmodule

bind line_pixel_generator lpg_checker u_chk (.*);

`default_nettype wire
